FILE: hw/rtl/status_led_mode_controller_macros.svh
// Assertion macros shared by the status LED mode controller checkers.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef STATUS_LED_MODE_CONTROLLER_MACROS_SVH
`define STATUS_LED_MODE_CONTROLLER_MACROS_SVH

// Clocked assertion with a synchronous active-low reset that disables it.
`define SLMC_ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("status LED controller assertion failed");

// Same, on the block's own clock and reset names.
`define SLMC_ASSERT(label, prop) \
    `SLMC_ASSERT_CLK(label, aclk, aresetn, prop)

`endif

FILE: hw/rtl/slmc_pkg.sv
// Shared types, codes and helper functions of the status LED mode controller.
// Depends on nothing; used by every module of the block.
package slmc_pkg;

    // Number of LEDs that are actually kept. The slot count follows the
    // three-bit LED index; slots at or above NUM_LEDS stay off.
    localparam int NUM_LEDS  = 8;
    localparam int LED_SLOTS = 8;

    typedef logic [1:0] opcode_t;
    localparam opcode_t OP_SET_ALL = 2'd0;
    localparam opcode_t OP_SET_ONE = 2'd1;
    localparam opcode_t OP_PROCESS = 2'd2;
    localparam opcode_t OP_READ    = 2'd3;

    typedef logic [2:0] mode_t;
    localparam mode_t MODE_OFF       = 3'd0;
    localparam mode_t MODE_ON        = 3'd1;
    localparam mode_t MODE_ONCE      = 3'd2;
    localparam mode_t MODE_FLASH     = 3'd3;
    localparam mode_t MODE_FLASH_ON  = 3'd4;
    localparam mode_t MODE_FLASH_OFF = 3'd5;

    typedef logic result_kind_t;
    localparam result_kind_t RES_REPORT   = 1'b0;
    localparam result_kind_t RES_READBACK = 1'b1;

    typedef struct packed {
        opcode_t     opcode;
        logic [2:0]  led_index;
        mode_t       led_mode;
        logic [7:0]  status_mask;
        logic        perform_update;
        logic        force_emit;
        logic [31:0] time_now;
    } slmc_in_t;

    typedef struct packed {
        result_kind_t result_kind;
        logic [7:0]   status_bits;
        mode_t        mode_read;
    } slmc_out_t;

    // Commands from the controller to the LED mode bank.
    typedef struct packed {
        logic       set_all;
        logic       set_one;
        logic       advance;
        logic [7:0] mask;
        logic [2:0] index;
        mode_t      mode;
    } bank_ctrl_t;

    function automatic logic mode_is_lit(input mode_t m);
        return (m == MODE_ON) || (m == MODE_ONCE) || (m == MODE_FLASH_ON);
    endfunction

    function automatic mode_t mode_advance(input mode_t m);
        mode_t r;
        r = m;
        case (m)
            MODE_ONCE:      r = MODE_OFF;
            MODE_FLASH:     r = MODE_FLASH_ON;
            MODE_FLASH_ON:  r = MODE_FLASH_OFF;
            MODE_FLASH_OFF: r = MODE_FLASH_ON;
            default:        r = m;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/status_led_mode_controller.sv
// Status LED mode controller: the top level with its input, deadline and result registers.
// Depends on slmc_pkg and slmc_led_bank.
//
// This block keeps a mode for each status LED (off, on, once, flash, flash-on,
// flash-off) and answers four kinds of input transfer: load every LED on or off
// from a mask, set one LED's mode, read one LED's mode back, and a process call
// that carries the current millisecond time. A process call reports a status
// byte when its time is strictly greater than the stored deadline (a plain
// unsigned compare with no wrap handling) or when force_emit is set; on, once
// and flash-on count as lit. With perform_update set the modes then advance,
// and whenever a report fires with a nonzero report_interval the deadline moves
// to time_now plus the interval, modulo 2^32. Mask loads, mode writes and
// process calls that do not fire produce no output transfer; mode codes six and
// seven are ignored on writes. The block accepts one input transfer per clock
// while its results are taken: an accepted item waits in the input register,
// is evaluated there against the current LED modes and deadline, and its result
// is loaded into the output register when the item moves on, which needs the
// output register free or being emptied.
// The output register alone decides stalls: while it holds a result that is
// not taken, the input register may still fill, and s_ready falls only when
// both are occupied. report_interval may be written through cfg_wr_en and
// cfg_wr_data while no item is in flight; it takes effect at once.
module status_led_mode_controller (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  slmc_pkg::slmc_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output slmc_pkg::slmc_out_t m_data,
    input  logic                cfg_wr_en,
    input  logic [31:0]         cfg_wr_data
);

    // Input register: the item currently under evaluation.
    logic                in_valid_reg, in_valid_next;
    slmc_pkg::slmc_in_t  in_reg,       in_next;

    // Result register facing the output channel.
    logic                out_valid_reg, out_valid_next;
    slmc_pkg::slmc_out_t out_reg,       out_next;

    // Report scheduling state and configuration.
    logic [31:0] deadline_reg, deadline_next;
    logic [31:0] interval_reg, interval_next;

    logic                 go;
    logic                 is_process;
    logic                 is_read;
    logic                 fire;
    logic                 has_result;
    slmc_pkg::bank_ctrl_t bank_ctrl;
    logic [7:0]           lit_bits;
    slmc_pkg::mode_t      rd_mode;

    // The held item moves on when the result register is free or being
    // emptied in this cycle. Items that give no result move on the same way.
    assign go      = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || go;

    assign is_process = (in_reg.opcode == slmc_pkg::OP_PROCESS);
    assign is_read    = (in_reg.opcode == slmc_pkg::OP_READ);
    assign fire       = (in_reg.time_now > deadline_reg) || in_reg.force_emit;
    assign has_result = is_read || (is_process && fire);

    // LED bank commands take effect only at the cycle the item moves on.
    always_comb begin
        bank_ctrl.set_all = go && (in_reg.opcode == slmc_pkg::OP_SET_ALL);
        bank_ctrl.set_one = go && (in_reg.opcode == slmc_pkg::OP_SET_ONE);
        bank_ctrl.advance = go && is_process && fire && in_reg.perform_update;
        bank_ctrl.mask    = in_reg.status_mask;
        bank_ctrl.index   = in_reg.led_index;
        bank_ctrl.mode    = in_reg.led_mode;
    end

    slmc_led_bank u_led_bank (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (bank_ctrl),
        .lit_bits (lit_bits),
        .rd_mode  (rd_mode)
    );

    // Input register: load on every accepted transfer.
    always_comb begin
        in_valid_next = in_valid_reg;
        in_next       = in_reg;
        if (go) begin
            in_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_next       = s_data;
        end
    end

    // The status byte is sampled before the modes advance, which happens at
    // the same clock edge that loads the result register.
    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (go) begin
            out_valid_next = has_result;
            if (is_read) begin
                out_next.result_kind = slmc_pkg::RES_READBACK;
                out_next.status_bits = 8'd0;
                out_next.mode_read   = rd_mode;
            end else begin
                out_next.result_kind = slmc_pkg::RES_REPORT;
                out_next.status_bits = lit_bits;
                out_next.mode_read   = slmc_pkg::MODE_OFF;
            end
        end
    end

    // A zero interval leaves the deadline where it is.
    always_comb begin
        deadline_next = deadline_reg;
        if (go && is_process && fire && (interval_reg != 32'd0)) begin
            deadline_next = in_reg.time_now + interval_reg;
        end
    end

    always_comb begin
        interval_next = interval_reg;
        if (cfg_wr_en) begin
            interval_next = cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            deadline_reg  <= 32'd0;
            interval_reg  <= 32'd0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            deadline_reg  <= deadline_next;
            interval_reg  <= interval_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        in_reg  <= in_next;
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

FILE: hw/rtl/slmc_led_bank.sv
// Per-LED mode registers with their set, step and lit-status logic.
// Depends on slmc_pkg.
module slmc_led_bank (
    input  logic                aclk,
    input  logic                aresetn,
    input  slmc_pkg::bank_ctrl_t ctrl,
    output logic [7:0]          lit_bits,
    output slmc_pkg::mode_t     rd_mode
);

    slmc_pkg::mode_t mode_reg  [slmc_pkg::LED_SLOTS];
    slmc_pkg::mode_t mode_next [slmc_pkg::LED_SLOTS];

    // Every LED updates independently; slots beyond the LED count never change.
    always_comb begin
        for (int i = 0; i < slmc_pkg::LED_SLOTS; i++) begin
            mode_next[i] = mode_reg[i];
            if (i < slmc_pkg::NUM_LEDS) begin
                if (ctrl.set_all) begin
                    mode_next[i] = ctrl.mask[i] ? slmc_pkg::MODE_ON : slmc_pkg::MODE_OFF;
                end else if (ctrl.set_one && (ctrl.index == 3'(i))
                             && (ctrl.mode <= slmc_pkg::MODE_FLASH_OFF)) begin
                    mode_next[i] = ctrl.mode;
                end else if (ctrl.advance) begin
                    mode_next[i] = slmc_pkg::mode_advance(mode_reg[i]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < slmc_pkg::LED_SLOTS; i++) begin
            if (!aresetn) begin
                mode_reg[i] <= slmc_pkg::MODE_OFF;
            end else begin
                mode_reg[i] <= mode_next[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < slmc_pkg::LED_SLOTS; i++) begin
            lit_bits[i] = slmc_pkg::mode_is_lit(mode_reg[i]);
        end
    end

    assign rd_mode = mode_reg[ctrl.index];

endmodule

FILE: hw/rtl/slmc_checker.sv
// Port-level checker for the status LED mode controller, bound to the top level.
// Depends on slmc_pkg and status_led_mode_controller_macros.svh.
`include "status_led_mode_controller_macros.svh"

module slmc_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input slmc_pkg::slmc_out_t m_data
);

    // A stalled result keeps its contents.
    `SLMC_ASSERT(a_out_hold, (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))

    // A readback carries no status byte.
    `SLMC_ASSERT(a_readback_clean, (m_valid && (m_data.result_kind == slmc_pkg::RES_READBACK)) |-> (m_data.status_bits == 8'd0))

    // A status report carries no mode.
    `SLMC_ASSERT(a_report_clean, (m_valid && (m_data.result_kind == slmc_pkg::RES_REPORT)) |-> (m_data.mode_read == slmc_pkg::MODE_OFF))

    // With the result register empty the input side can always take a transfer.
    `SLMC_ASSERT(a_ready_when_empty, !m_valid |-> s_ready)

endmodule

bind status_led_mode_controller slmc_checker u_slmc_checker (.*);

FILE: sim/status_led_mode_controller_test.sv
// Self-checking testbench for the status LED mode controller.
// Depends on slmc_pkg and status_led_mode_controller; drives both handshake channels
// and the report_interval register, and checks every output transfer against a shadow model.
module status_led_mode_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Mode codes six and seven have no meaning; writes carrying them must be dropped.
    localparam slmc_pkg::mode_t MODE_UNUSED_LO = 3'd6;
    localparam slmc_pkg::mode_t MODE_UNUSED_HI = 3'd7;

    // A result passes through the input and output registers, so these spare cycles
    // cover any item still inside the pipeline when the last result has come out.
    localparam int DRAIN_CYCLES = 6;
    // Longest stretch without any transfer that is still considered alive. The
    // deliberate output hold-off is far shorter than this.
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 250;

    localparam logic [31:0] PHASE_INTERVAL [NUM_PHASES] = '{
        32'd0, 32'd1, 32'd10, 32'hFFFF_FFFF, 32'd100, 32'd0, 32'd3, 32'd7
    };

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    slmc_pkg::slmc_in_t  s_data      = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    slmc_pkg::slmc_out_t m_data;
    logic                cfg_wr_en   = 1'b0;
    logic [31:0]         cfg_wr_data = 32'd0;

    // Operations waiting to be offered on the input channel, and the results
    // that the shadow model says the block owes us, oldest first.
    slmc_pkg::slmc_in_t  ops_to_send[$];
    slmc_pkg::slmc_out_t led_results_due[$];
    int unsigned ops_queued    = 0;
    int unsigned ops_accepted  = 0;
    int unsigned fail_count    = 0;

    // Shadow copy of the block state: LED modes, report deadline and the interval.
    slmc_pkg::mode_t shadow_modes [slmc_pkg::LED_SLOTS];
    logic [31:0]     shadow_deadline = 32'd0;
    logic [31:0]     shadow_interval = 32'd0;

    // Stimulus knobs shared with the generator and the handshake processes.
    logic [31:0] gen_clock       = 32'd0;
    int unsigned step_max        = 4;
    logic        idle_enable     = 1'b1;
    int unsigned hold_requests   = 0;

    status_led_mode_controller uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        for (int i = 0; i < slmc_pkg::LED_SLOTS; i++) begin
            shadow_modes[i] = slmc_pkg::MODE_OFF;
        end
    end

    // Shadow model: applies one accepted operation to the shadow state and
    // queues the result that the block has to produce for it, if any.
    task automatic apply_led_op(input slmc_pkg::slmc_in_t op);
        slmc_pkg::slmc_out_t res;
        logic [7:0]          lit;
        case (op.opcode)
            slmc_pkg::OP_SET_ALL: begin
                for (int i = 0; i < slmc_pkg::NUM_LEDS; i++) begin
                    shadow_modes[i] = op.status_mask[i] ? slmc_pkg::MODE_ON
                                                        : slmc_pkg::MODE_OFF;
                end
            end
            slmc_pkg::OP_SET_ONE: begin
                if (op.led_index < slmc_pkg::NUM_LEDS
                    && op.led_mode <= slmc_pkg::MODE_FLASH_OFF) begin
                    shadow_modes[op.led_index] = op.led_mode;
                end
            end
            slmc_pkg::OP_PROCESS: begin
                // Plain unsigned compare; a wrapped clock is not treated specially.
                if (op.time_now > shadow_deadline || op.force_emit) begin
                    lit = 8'h00;
                    for (int i = 0; i < slmc_pkg::NUM_LEDS; i++) begin
                        lit[i] = (shadow_modes[i] == slmc_pkg::MODE_ON)
                                 || (shadow_modes[i] == slmc_pkg::MODE_ONCE)
                                 || (shadow_modes[i] == slmc_pkg::MODE_FLASH_ON);
                    end
                    // The status byte reflects the modes before they advance.
                    if (op.perform_update) begin
                        for (int i = 0; i < slmc_pkg::NUM_LEDS; i++) begin
                            case (shadow_modes[i])
                                slmc_pkg::MODE_ONCE:
                                    shadow_modes[i] = slmc_pkg::MODE_OFF;
                                slmc_pkg::MODE_FLASH:
                                    shadow_modes[i] = slmc_pkg::MODE_FLASH_ON;
                                slmc_pkg::MODE_FLASH_ON:
                                    shadow_modes[i] = slmc_pkg::MODE_FLASH_OFF;
                                slmc_pkg::MODE_FLASH_OFF:
                                    shadow_modes[i] = slmc_pkg::MODE_FLASH_ON;
                                default: ;
                            endcase
                        end
                    end
                    if (shadow_interval != 32'd0) begin
                        shadow_deadline = op.time_now + shadow_interval;
                    end
                    res.result_kind = slmc_pkg::RES_REPORT;
                    res.status_bits = lit;
                    res.mode_read   = slmc_pkg::MODE_OFF;
                    led_results_due.push_back(res);
                end
            end
            default: begin
                res.result_kind = slmc_pkg::RES_READBACK;
                res.status_bits = 8'h00;
                res.mode_read   = (op.led_index < slmc_pkg::NUM_LEDS)
                                  ? shadow_modes[op.led_index] : slmc_pkg::MODE_OFF;
                led_results_due.push_back(res);
            end
        endcase
    endtask

    // Compares one output transfer with the oldest owed result, field by field.
    task automatic check_result(input slmc_pkg::slmc_out_t got);
        slmc_pkg::slmc_out_t want;
        if (led_results_due.size() == 0) begin
            $display("%0t: result with nothing owed: kind %0d bits %02h mode %0d",
                     $time, got.result_kind, got.status_bits, got.mode_read);
            fail_count++;
        end else begin
            want = led_results_due.pop_front();
            if (got.result_kind !== want.result_kind) begin
                $display("%0t: result_kind expected %0d actual %0d",
                         $time, want.result_kind, got.result_kind);
                fail_count++;
            end
            if (got.status_bits !== want.status_bits) begin
                $display("%0t: status_bits expected %02h actual %02h",
                         $time, want.status_bits, got.status_bits);
                fail_count++;
            end
            if (got.mode_read !== want.mode_read) begin
                $display("%0t: mode_read expected %0d actual %0d",
                         $time, want.mode_read, got.mode_read);
                fail_count++;
            end
        end
    endtask

    // Input driver. An offered item stays put until its transfer; only then
    // (or while nothing is offered) may the next item go out or an idle cycle
    // be inserted. Acceptance is judged on the values from before this edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                apply_led_op(s_data);
                ops_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (ops_to_send.size() != 0 && !(idle_enable && $urandom_range(99) < 25)) begin
                    s_data  <= ops_to_send.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor. Checks each transfer and throttles m_ready at random; on
    // request it holds m_ready low for a long stretch so that the block fills
    // up and has to drop s_ready while the driver keeps offering items.
    always @(posedge aclk) begin : result_monitor
        int unsigned hold_left;
        int unsigned holds_served;
        logic        ready_next;
        if (!aresetn) begin
            hold_left    = 0;
            holds_served = 0;
            m_ready     <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                check_result(m_data);
            end
            if (hold_requests != holds_served) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else begin
                ready_next = !(idle_enable && $urandom_range(99) < 25);
            end
            m_ready <= ready_next;
        end
    end

    // Watchdog: ends the run if no transfer happens on either channel for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic slmc_pkg::slmc_in_t led_op(input slmc_pkg::opcode_t op,
                                                  input logic [2:0] idx,
                                                  input slmc_pkg::mode_t mode,
                                                  input logic [7:0] mask,
                                                  input logic upd, input logic frc,
                                                  input logic [31:0] now);
        slmc_pkg::slmc_in_t it;
        it.opcode         = op;
        it.led_index      = idx;
        it.led_mode       = mode;
        it.status_mask    = mask;
        it.perform_update = upd;
        it.force_emit     = frc;
        it.time_now       = now;
        return it;
    endfunction

    // Random operation. Time mostly creeps forward in steps sized to the
    // current interval, so process calls land on both sides of the deadline;
    // now and then it jumps anywhere, which also exercises the wrap.
    function automatic slmc_pkg::slmc_in_t random_led_op();
        slmc_pkg::slmc_in_t it;
        int unsigned        pick;
        it.led_index      = 3'($urandom_range(7));
        it.led_mode       = ($urandom_range(9) == 0)
                            ? slmc_pkg::mode_t'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO))
                            : slmc_pkg::mode_t'($urandom_range(slmc_pkg::MODE_FLASH_OFF));
        it.status_mask    = 8'($urandom);
        it.perform_update = ($urandom_range(9) < 7);
        it.force_emit     = ($urandom_range(9) < 2);
        if ($urandom_range(19) == 0) begin
            gen_clock = $urandom;
        end else begin
            gen_clock = gen_clock + $urandom_range(step_max);
        end
        it.time_now = gen_clock;
        pick = $urandom_range(99);
        if (pick < 40) begin
            it.opcode = slmc_pkg::OP_PROCESS;
        end else if (pick < 65) begin
            it.opcode = slmc_pkg::OP_SET_ONE;
        end else if (pick < 85) begin
            it.opcode = slmc_pkg::OP_READ;
        end else begin
            it.opcode = slmc_pkg::OP_SET_ALL;
        end
        return it;
    endfunction

    task automatic queue_op(input slmc_pkg::slmc_in_t it);
        ops_to_send.push_back(it);
        ops_queued++;
    endtask

    // Waits until every queued item has been taken and every owed result has
    // come out, then lets the pipeline settle for items that produce nothing.
    task automatic wait_drained();
        while (ops_accepted != ops_queued || led_results_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // The register is only written while the block is idle, so the shadow copy
    // can follow it right away.
    task automatic write_interval(input logic [31:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        shadow_interval = value;
    endtask

    initial begin : stimulus
        logic [31:0] iv;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, with the interval still at its reset value of zero.
        // Reading after reset must give off.
        queue_op(led_op(slmc_pkg::OP_READ, 3'd0, slmc_pkg::MODE_OFF, 8'h00,
                        1'b0, 1'b0, 32'd0));
        // Time zero is not past the zero deadline: no report. Forcing reports anyway.
        queue_op(led_op(slmc_pkg::OP_PROCESS, 3'd0, slmc_pkg::MODE_OFF, 8'h00,
                        1'b0, 1'b0, 32'd0));
        queue_op(led_op(slmc_pkg::OP_PROCESS, 3'd0, slmc_pkg::MODE_OFF, 8'h00,
                        1'b1, 1'b1, 32'd0));
        queue_op(led_op(slmc_pkg::OP_SET_ALL, 3'd0, slmc_pkg::MODE_OFF, 8'hFF,
                        1'b0, 1'b0, 32'd0));
        queue_op(led_op(slmc_pkg::OP_READ, 3'd7, slmc_pkg::MODE_OFF, 8'h00,
                        1'b0, 1'b0, 32'd0));
        queue_op(led_op(slmc_pkg::OP_PROCESS, 3'd7, slmc_pkg::MODE_OFF, 8'h00,
                        1'b0, 1'b0, 32'hFFFF_FFFF));
        queue_op(led_op(slmc_pkg::OP_SET_ALL, 3'd0, slmc_pkg::MODE_OFF, 8'h00,
                        1'b0, 1'b0, 32'd0));
        // One LED in each mode, then two writes with unused mode codes.
        queue_op(led_op(slmc_pkg::OP_SET_ONE, 3'd0, slmc_pkg::MODE_ONCE, 8'h00,
                        1'b0, 1'b0, 32'd0));
        queue_op(led_op(slmc_pkg::OP_SET_ONE, 3'd1, slmc_pkg::MODE_FLASH, 8'h00,
                        1'b0, 1'b0, 32'd0));
        queue_op(led_op(slmc_pkg::OP_SET_ONE, 3'd2, slmc_pkg::MODE_FLASH_ON, 8'h00,
                        1'b0, 1'b0, 32'd0));
        queue_op(led_op(slmc_pkg::OP_SET_ONE, 3'd3, slmc_pkg::MODE_FLASH_OFF, 8'h00,
                        1'b0, 1'b0, 32'd0));
        queue_op(led_op(slmc_pkg::OP_SET_ONE, 3'd4, slmc_pkg::MODE_ON, 8'h00,
                        1'b0, 1'b0, 32'd0));
        queue_op(led_op(slmc_pkg::OP_SET_ONE, 3'd5, MODE_UNUSED_LO, 8'h00,
                        1'b0, 1'b0, 32'd0));
        queue_op(led_op(slmc_pkg::OP_SET_ONE, 3'd6, MODE_UNUSED_HI, 8'h00,
                        1'b0, 1'b0, 32'd0));
        queue_op(led_op(slmc_pkg::OP_SET_ONE, 3'd7, slmc_pkg::MODE_ON, 8'h00,
                        1'b0, 1'b0, 32'd0));
        // Three advancing reports walk once, flash and the flash pair through
        // their transitions; a fourth report without update leaves them alone.
        queue_op(led_op(slmc_pkg::OP_PROCESS, 3'd0, slmc_pkg::MODE_OFF, 8'h00,
                        1'b1, 1'b0, 32'd1));
        queue_op(led_op(slmc_pkg::OP_PROCESS, 3'd0, slmc_pkg::MODE_OFF, 8'h00,
                        1'b1, 1'b1, 32'd2));
        queue_op(led_op(slmc_pkg::OP_PROCESS, 3'd0, slmc_pkg::MODE_OFF, 8'h00,
                        1'b1, 1'b0, 32'd3));
        queue_op(led_op(slmc_pkg::OP_PROCESS, 3'd0, slmc_pkg::MODE_OFF, 8'h00,
                        1'b0, 1'b0, 32'd4));
        queue_op(led_op(slmc_pkg::OP_READ, 3'd1, slmc_pkg::MODE_OFF, 8'h00,
                        1'b0, 1'b0, 32'd0));
        queue_op(led_op(slmc_pkg::OP_READ, 3'd3, slmc_pkg::MODE_OFF, 8'h00,
                        1'b0, 1'b0, 32'd0));
        queue_op(led_op(slmc_pkg::OP_READ, 3'd5, slmc_pkg::MODE_OFF, 8'h00,
                        1'b0, 1'b0, 32'd0));
        queue_op(led_op(slmc_pkg::OP_SET_ALL, 3'd0, slmc_pkg::MODE_OFF, 8'h5A,
                        1'b0, 1'b0, 32'd0));
        queue_op(led_op(slmc_pkg::OP_READ, 3'd6, slmc_pkg::MODE_OFF, 8'h00,
                        1'b0, 1'b0, 32'd0));
        wait_drained();

        // Random part, one phase per interval setting. Phase two also asks for
        // the long output hold-off; phase four runs without any idle cycles.
        for (int p = 0; p < NUM_PHASES; p++) begin
            iv = (p == 5) ? $urandom : PHASE_INTERVAL[p];
            write_interval(iv);
            step_max    = (iv == 32'd0) ? 4 : ((iv > 32'd60) ? 120 : 2 * iv + 1);
            idle_enable = (p != 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                queue_op(random_led_op());
            end
            if (p == 2) begin
                hold_requests++;
            end
            wait_drained();
        end

        if (fail_count == 0 && led_results_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
